>>> rtl/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the link-port paddle controller.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE = 1'd1;

    localparam logic [14:0] DEADZONE_RESET = 15'd1638;
    localparam logic [15:0] MOUSE_RESET    = 16'h7800;

    localparam logic [7:0]  PADDLE_MIN     = 8'h3F;
    localparam logic [7:0]  PADDLE_MAX     = 8'h97;
    localparam logic [7:0]  PADDLE_SPAN    = 8'd88;
    localparam logic [15:0] BIAS_Q15       = 16'd36045;
    localparam logic [15:0] STICK_ONE      = 16'd32768;
    localparam logic [7:0]  MOUSE_GAIN     = 8'd77;
    localparam logic [9:0]  TOUCH_MAX      = 10'd512;
    localparam logic [7:0]  BUTTON_REPLY   = 8'h8E;
    localparam logic [7:0]  DISABLED_REPLY = 8'hFF;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_STICK,
        MODE_MOUSE,
        MODE_TOUCH
    } t_mode;

    typedef enum logic [2:0] {
        REPLY_OFF,
        REPLY_STICK,
        REPLY_MOUSE,
        REPLY_TOUCH,
        REPLY_BUTTON
    } t_reply;

    typedef struct packed {
        logic   load;
        logic   square;
        logic   cube;
        logic   bias;
        logic   emit;
        t_reply sel;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  out_free;
    } t_status;

endpackage

>>> rtl/lpp_ctrl.sv
// ----------------------------------------------------------------------------
// lpp_ctrl
// Sequencer: picks the reply kind per request and steps the stick pipeline.
// ----------------------------------------------------------------------------
module lpp_ctrl
    import lpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_CUBE,
        S_BIAS,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_reply r_sel, n_sel;
    logic   r_phase, n_phase;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.mode == MODE_OFF) begin
                        n_sel = REPLY_OFF;
                    end else if (!r_phase) begin
                        n_sel = REPLY_BUTTON;
                    end else begin
                        unique case (i_status.mode)
                            MODE_STICK: n_sel = REPLY_STICK;
                            MODE_MOUSE: n_sel = REPLY_MOUSE;
                            default:    n_sel = REPLY_TOUCH;
                        endcase
                    end
                    n_state = (n_sel == REPLY_STICK) ? S_SQ : S_EMIT;
                end
            end
            S_SQ:   n_state = S_CUBE;
            S_CUBE: n_state = S_BIAS;
            S_BIAS: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                    if (r_sel != REPLY_OFF) begin
                        n_phase = ~r_phase;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= REPLY_OFF;
            r_phase <= 1'b1;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_phase <= n_phase;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.square = (r_state == S_SQ);
    assign o_cmd.cube   = (r_state == S_CUBE);
    assign o_cmd.bias   = (r_state == S_BIAS);
    assign o_cmd.emit   = (r_state == S_EMIT) && i_status.out_free;
    assign o_cmd.sel    = r_sel;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready)
        else $error("accepted a request while busy");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd.emit |=> $stable(r_phase))
        else $error("phase changed without a reply");

    a_stick_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.square |=> o_cmd.cube ##1 o_cmd.bias)
        else $error("stick steps out of order");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.square, o_cmd.cube, o_cmd.bias, o_cmd.emit}))
        else $error("overlapping datapath commands");

endmodule

>>> rtl/lpp_dp.sv
// ----------------------------------------------------------------------------
// lpp_dp
// Datapath: config registers, stick curve, mouse and touch trackers, reply.
// ----------------------------------------------------------------------------
module lpp_dp
    import lpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [15:0]    i_stick_x,
    input  logic signed [15:0]    i_mouse_dx,
    input  logic                  i_button_down,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_reply_byte
);

    t_mode              r_mode;
    logic [14:0]        r_deadzone;
    logic [15:0]        r_mouse_pos;
    logic [9:0]         r_touch_acc;
    logic               r_out_valid;
    logic [7:0]         r_reply;

    logic               r_neg;
    logic [15:0]        r_mag;
    logic [30:0]        r_sq;
    logic [15:0]        r_cube;
    logic [15:0]        r_bias;
    logic signed [22:0] r_mprod;
    logic signed [15:0] r_dx;
    logic               r_btn;

    logic [15:0]        mag_abs;
    logic [46:0]        cube_full;
    logic [31:0]        bias_full;
    logic [16:0]        bias_q;
    logic [16:0]        stick_off;
    logic [24:0]        stick_prod;
    logic signed [23:0] mouse_sum;
    logic [15:0]        mouse_next;
    logic signed [17:0] touch_sum;
    logic [9:0]         touch_next;
    logic [16:0]        touch_prod;
    logic [7:0]         n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_deadzone <= DEADZONE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE:     r_mode     <= t_mode'(i_cfg_data[1:0]);
                CFG_DEADZONE: r_deadzone <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    assign mag_abs    = i_stick_x[15] ? 16'(-i_stick_x) : 16'(i_stick_x);
    assign cube_full  = 47'(r_sq) * 47'(r_mag);
    assign bias_full  = 32'(r_cube) * 32'(BIAS_Q15);
    assign bias_q     = bias_full[31:15];
    assign stick_off  = r_neg ? (17'(STICK_ONE) - 17'(r_bias))
                              : (17'(STICK_ONE) + 17'(r_bias));
    assign stick_prod = 25'(stick_off) * 25'(PADDLE_SPAN);

    assign mouse_sum = $signed({8'd0, r_mouse_pos}) + 24'(r_mprod);
    always_comb begin
        if (mouse_sum < $signed({8'd0, PADDLE_MIN, 8'd0})) begin
            mouse_next = {PADDLE_MIN, 8'd0};
        end else if (mouse_sum > $signed({8'd0, PADDLE_MAX, 8'd0})) begin
            mouse_next = {PADDLE_MAX, 8'd0};
        end else begin
            mouse_next = mouse_sum[15:0];
        end
    end

    assign touch_sum = $signed({8'd0, r_touch_acc}) + 18'(r_dx);
    always_comb begin
        if (touch_sum < 0) begin
            touch_next = '0;
        end else if (touch_sum > $signed({8'd0, TOUCH_MAX})) begin
            touch_next = TOUCH_MAX;
        end else begin
            touch_next = touch_sum[9:0];
        end
    end
    assign touch_prod = 17'(touch_next) * 17'(PADDLE_SPAN);

    always_comb begin
        case (i_cmd.sel)
            REPLY_STICK:  n_reply = PADDLE_MIN + stick_prod[23:16];
            REPLY_MOUSE:  n_reply = mouse_next[15:8];
            REPLY_TOUCH:  n_reply = PADDLE_MIN + {1'b0, touch_prod[15:9]};
            REPLY_BUTTON: n_reply = (r_btn && (r_mode == MODE_MOUSE)) ? BUTTON_REPLY : 8'd0;
            default:      n_reply = DISABLED_REPLY;
        endcase
    end

    // Working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= i_stick_x[15];
            r_mag   <= (mag_abs < {1'b0, r_deadzone}) ? 16'd0 : mag_abs;
            r_mprod <= 23'(i_mouse_dx) * $signed({15'd0, MOUSE_GAIN});
            r_dx    <= i_mouse_dx;
            r_btn   <= i_button_down;
        end
        if (i_cmd.square) begin
            r_sq <= 31'(r_mag) * 31'(r_mag);
        end
        if (i_cmd.cube) begin
            r_cube <= cube_full[45:30];
        end
        if (i_cmd.bias) begin
            r_bias <= (bias_q > 17'(STICK_ONE)) ? STICK_ONE : bias_q[15:0];
        end
        if (i_cmd.emit) begin
            r_reply <= n_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_pos <= MOUSE_RESET;
            r_touch_acc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit && (i_cmd.sel == REPLY_MOUSE)) begin
                r_mouse_pos <= mouse_next;
            end
            if (i_cmd.emit && (i_cmd.sel == REPLY_TOUCH)) begin
                r_touch_acc <= touch_next;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.mode     = r_mode;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_reply_byte      = r_reply;

    a_mouse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (i_cmd.sel == REPLY_MOUSE))
            |=> (r_reply >= PADDLE_MIN) && (r_reply <= PADDLE_MAX))
        else $error("mouse position out of paddle range");

    a_touch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_touch_acc <= TOUCH_MAX)
        else $error("touch accumulator above limit");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("reply not presented");

endmodule

>>> rtl/link_port_paddle_controller.sv
// ----------------------------------------------------------------------------
// link_port_paddle_controller
// Paddle controller answering link-port transfers with one reply byte each.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per link transfer (stick, mouse motion,
//   button). m_axis returns the reply byte for it, one reply per request.
//   The config port writes control_mode (index 0) and stick_deadzone
//   (index 1); write it only while no request is in flight.
//   A stick position reply passes the square, cube, bias and reply stages
//   of the stick datapath before m_axis_tvalid; all other replies go
//   straight to the reply stage. One request is in flight at a time, so
//   a new request is accepted only once the last one has been emitted.
//   The reply sits in an output register; the next request is accepted
//   while it waits, and its result is held back until the register frees.
//   Reset: mode disabled, deadzone 1638, position byte next, mouse at
//   120.0, touch accumulator 0, no reply pending.
// ----------------------------------------------------------------------------
module link_port_paddle_controller
    import lpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] stick_x, [31:16] mouse_dx, [32] button_down, [39:33] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] reply_byte
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    lpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    lpp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_stick_x     (s_axis_tdata[15:0]),
        .i_mouse_dx    (s_axis_tdata[31:16]),
        .i_button_down (s_axis_tdata[32]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_reply_byte  (m_axis_tdata)
    );

endmodule

>>> tb/sv/tb_link_port_paddle_controller.sv
// ----------------------------------------------------------------------------
// tb_link_port_paddle_controller
// Self-checking testbench for the link-port paddle controller.
// ----------------------------------------------------------------------------
// Each accepted request runs through a cycle-free model of the paddle logic:
// the stick curve, the mouse and touch paths and the position/button phase.
// The model queues the reply it predicts, and every reply the block returns
// is compared with the oldest queued one. Directed tests cover the reset
// defaults, the deadzone and saturation edges, both clamps of the mouse and
// touch paths and mode changes between the two phases. A random part then
// runs through many register settings. Both sides of the stream add random
// gaps between requests, with some stretches that run at full rate.
// ----------------------------------------------------------------------------
module tb_link_port_paddle_controller;
    import lpp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 8;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [15:0] stick_x, [31:16] mouse_dx, [32] button_down, [39:33] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] reply_byte
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // paddle model state and registers
    t_mode       paddle_mode  = MODE_OFF;
    logic [14:0] deadzone_lvl = DEADZONE_RESET;
    logic        pos_next     = 1'b1;
    logic [15:0] mouse_q88    = MOUSE_RESET;
    logic [9:0]  touch_acc    = '0;

    logic [7:0] expected_replies[$];
    int         err_cnt     = 0;
    int         idle_cycles = 0;
    int         ready_hold  = 0;
    bit         no_idle     = 1'b0;

    link_port_paddle_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] stick_to_paddle(input logic signed [15:0] sx);
        longint mag;
        longint tilt;
        mag = (sx < 0) ? -longint'(sx) : longint'(sx);
        if (mag < longint'(deadzone_lvl)) mag = 0;
        mag = (mag * mag * mag) >> 30;
        mag = (mag * longint'(BIAS_Q15)) >> 15;
        if (mag > longint'(STICK_ONE)) mag = longint'(STICK_ONE);
        tilt = (sx < 0) ? -mag : mag;
        return PADDLE_MIN + 8'(((tilt + 32768) * longint'(PADDLE_SPAN)) >> 16);
    endfunction

    function automatic logic [7:0] mouse_to_paddle(input logic signed [15:0] dx);
        int pos;
        pos = int'(mouse_q88) + int'(dx) * int'(MOUSE_GAIN);
        if (pos < int'(PADDLE_MIN) * 256) pos = int'(PADDLE_MIN) * 256;
        if (pos > int'(PADDLE_MAX) * 256) pos = int'(PADDLE_MAX) * 256;
        mouse_q88 = pos[15:0];
        return mouse_q88[15:8];
    endfunction

    function automatic logic [7:0] touch_to_paddle(input logic signed [15:0] dx);
        int acc;
        acc = int'(touch_acc) + int'(dx);
        if (acc < 0) acc = 0;
        if (acc > int'(TOUCH_MAX)) acc = int'(TOUCH_MAX);
        touch_acc = acc[9:0];
        return PADDLE_MIN + 8'((acc * int'(PADDLE_SPAN)) >>> 9);
    endfunction

    function automatic logic [7:0] predict_reply(input logic [15:0] sx, input logic [15:0] dx,
                                                 input logic btn);
        logic [7:0] r;
        if (paddle_mode == MODE_OFF) begin
            r = DISABLED_REPLY;
        end else if (pos_next) begin
            pos_next = 1'b0;
            case (paddle_mode)
                MODE_STICK: r = stick_to_paddle(sx);
                MODE_MOUSE: r = mouse_to_paddle(dx);
                default:    r = touch_to_paddle(dx);
            endcase
        end else begin
            pos_next = 1'b1;
            r = (btn && paddle_mode == MODE_MOUSE) ? BUTTON_REPLY : 8'h00;
        end
        return r;
    endfunction

    task automatic send_request(input logic [15:0] sx, input logic [15:0] dx,
                                input logic btn);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, btn, dx, sx};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_replies.push_back(predict_reply(sx, dx, btn));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // call only after wait_idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MODE) paddle_mode = t_mode'(val[1:0]);
        else deadzone_lvl = val;
        @(posedge i_clk);
    endtask

    task automatic test_disabled_at_reset();
        send_request(16'h7FFF, 16'h8000, 1'b1);
        send_request(16'h8000, 16'h7FFF, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        wait_idle();
    endtask

    task automatic test_stick_curve();
        write_reg(CFG_MODE, {13'h1FFF, MODE_STICK});
        // default deadzone edge, then full deflection both ways
        send_request(16'd1637, 16'h0000, 1'b1);
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'd1638, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'h8000, 16'hFFFF, 1'b1);
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'h7FFF, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        wait_idle();
        write_reg(CFG_DEADZONE, 15'h7FFF);
        send_request(16'h7FFE, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'h8000, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        wait_idle();
        write_reg(CFG_DEADZONE, 15'h0000);
        send_request(16'hC000, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        wait_idle();
    endtask

    task automatic test_mouse_motion();
        write_reg(CFG_MODE, {13'h0000, MODE_MOUSE});
        send_request(16'h0000, 16'h7FFF, 1'b1);
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'h0000, 16'h8000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b0);
        send_request(16'h0000, 16'd100, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        wait_idle();
    endtask

    task automatic test_touch_accumulate();
        write_reg(CFG_MODE, {13'h1555, MODE_TOUCH});
        send_request(16'h0000, 16'hFFFB, 1'b1);
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'h0000, 16'h7FFF, 1'b1);
        send_request(16'h0000, 16'h0000, 1'b0);
        send_request(16'h0000, 16'hFF00, 1'b1);
        wait_idle();
    endtask

    // touch left the button byte pending; it must survive the mode changes
    task automatic test_mode_change_keeps_phase();
        write_reg(CFG_MODE, {13'h0AAA, MODE_OFF});
        send_request(16'h1234, 16'h4321, 1'b1);
        wait_idle();
        write_reg(CFG_MODE, {13'h0000, MODE_MOUSE});
        send_request(16'h0000, 16'h0000, 1'b1);
        send_request(16'h0000, 16'hFFF0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_settings();
        int          sel;
        int          v;
        logic [1:0]  mode_pick;
        logic [14:0] dz_pick;
        logic [15:0] sx;
        logic [15:0] dx;
        for (int ph = 0; ph < 14; ph++) begin
            mode_pick = (ph < 8) ? 2'(ph) : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       dz_pick = 15'h0000;
                1:       dz_pick = 15'h7FFF;
                2:       dz_pick = DEADZONE_RESET;
                3:       dz_pick = 15'($urandom_range(0, 4000));
                default: dz_pick = 15'($urandom);
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(CFG_DEADZONE, dz_pick);
            write_reg(CFG_MODE, {13'($urandom), mode_pick});
            for (int n = 0; n < 130; n++) begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: begin
                        case ($urandom_range(0, 3))
                            0:       sx = 16'h8000;
                            1:       sx = 16'h7FFF;
                            2:       sx = 16'h8001;
                            default: sx = 16'h0000;
                        endcase
                    end
                    1: begin
                        v = int'(deadzone_lvl) + $urandom_range(0, 4) - 2;
                        sx = $urandom_range(0, 1) ? 16'(-v) : 16'(v);
                    end
                    default: sx = 16'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       dx = 16'($urandom);
                    1:       dx = 16'($urandom_range(0, 40) - 20);
                    default: dx = 16'($urandom_range(0, 400) - 200);
                endcase
                send_request(sx, dx, 1'($urandom));
            end
            wait_idle();
        end
    endtask

    // reply side: random stalls, results checked in order
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_hold = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("reply 0x%02h with no request outstanding", m_axis_tdata);
            end else begin
                want = expected_replies.pop_front();
                if (m_axis_tdata !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("reply_byte mismatch: expected 0x%02h, got 0x%02h",
                                 want, m_axis_tdata);
                end
            end
            ready_hold = no_idle ? 0 : $urandom_range(0, 12);
            if (ready_hold != 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (ready_hold <= 1) m_axis_tready <= 1'b1;
            ready_hold--;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_at_reset();
        test_stick_curve();
        test_mouse_motion();
        test_touch_accumulate();
        test_mode_change_keeps_phase();
        test_random_settings();
        wait_idle();
        if (err_cnt == 0 && expected_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lpp_pkg.sv
rtl/lpp_ctrl.sv
rtl/lpp_dp.sv
rtl/link_port_paddle_controller.sv
tb/sv/tb_link_port_paddle_controller.sv
